### rtl/rcd_pkg.sv
// Shared types and constants for the command deframer.
// Character codes, result kinds, parse phases, config and result structs.
// No dependencies.
package rcd_pkg;

  localparam int LENGTH_BITS_DEF = 32;

  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam logic [7:0]  MAX_ARG_COUNT_RST   = 8'd255;
  localparam logic [31:0] MAX_BULK_LENGTH_RST = 32'h2000_0000;

  // Configuration register indexes
  localparam logic CFG_MAX_ARG_COUNT   = 1'b0;
  localparam logic CFG_MAX_BULK_LENGTH = 1'b1;

  typedef enum logic [2:0] {
    KIND_HEADER    = 3'd0,
    KIND_DATA      = 3'd1,
    KIND_NULL_ARG  = 3'd2,
    KIND_EMPTY_ARG = 3'd3,
    KIND_BAD_HDR   = 3'd4,
    KIND_NOT_ARRAY = 3'd5,
    KIND_OVERSIZE  = 3'd6
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE         = 4'd0,
    PH_CNT_START    = 4'd1,
    PH_CNT_DIGITS   = 4'd2,
    PH_ARG_HDR      = 4'd3,
    PH_LEN_START    = 4'd4,
    PH_LEN_DIGITS   = 4'd5,
    PH_PAYLOAD      = 4'd6,
    PH_SKIP_IDLE    = 4'd7,
    PH_SKIP_ARGHDR  = 4'd8,
    PH_SKIP_PAYLOAD = 4'd9
  } phase_t;

  typedef struct packed {
    logic [7:0]  max_arg_count;
    logic [31:0] max_bulk_length;
  } cfg_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] arg_index;
    logic [7:0] arg_count;
    logic [7:0] data_byte;
    logic       last_in_arg;
    logic       last_in_msg;
  } res_t;

endpackage

### rtl/resp_command_deframer_unit.sv
// A byte's result passes from the input register through the parse logic into the
//   output register.
// Throughput: one byte per cycle; the output register stalls the input only when a
//   result is pending and the byte in the input register produces another one.
// Reset (rst_n, synchronous, active low): parser idle, both registers empty,
//   max_arg_count = 255, max_bulk_length = 2^29.
module resp_command_deframer_unit #(
  parameter int LENGTH_BITS = rcd_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // byte stream in
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte,
  // parsed results out
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_kind,
  output logic [7:0]  out_arg_index,
  output logic [7:0]  out_arg_count,
  output logic [7:0]  out_data_byte,
  output logic        out_last_in_arg,
  output logic        out_last_in_msg,
  // configuration writes
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  rcd_pkg::cfg_t cfg;
  rcd_pkg::res_t res, res_r;
  logic          res_valid;

  logic          in_valid_r, in_valid_nxt;
  logic [7:0]    in_byte_r;
  logic          out_valid_r, out_valid_nxt;
  logic          advance;

  rcd_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // The byte in the input register moves on unless it would produce a result
  // while the output register still holds one that is not being taken.
  assign advance  = in_valid_r && (!res_valid || !out_valid_r || out_ready);
  assign in_ready = !in_valid_r || advance;

  rcd_parser #(
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .byte_in   (in_byte_r),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  // Input register: refilled in the same cycle it drains.
  always_comb begin
    in_valid_nxt = in_valid_r;
    if (in_valid && in_ready) begin
      in_valid_nxt = 1'b1;
    end else if (advance) begin
      in_valid_nxt = 1'b0;
    end
  end

  // Output register: a new result replaces one being taken this cycle.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (advance && res_valid) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers, no reset needed
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_byte_r <= in_byte;
    end
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_kind        = res_r.kind;
  assign out_arg_index   = res_r.arg_index;
  assign out_arg_count   = res_r.arg_count;
  assign out_data_byte   = res_r.data_byte;
  assign out_last_in_arg = res_r.last_in_arg;
  assign out_last_in_msg = res_r.last_in_msg;

  // A byte that would produce a result behind a stalled output must be held.
  a_hold_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid_r && res_valid && out_valid_r && !out_ready) |=>
      (in_valid_r && $stable(in_byte_r)))
    else $error("input transaction dropped while output stalled");

  a_errors_end_msg: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (res_r.kind == rcd_pkg::KIND_BAD_HDR ||
                     res_r.kind == rcd_pkg::KIND_NOT_ARRAY ||
                     res_r.kind == rcd_pkg::KIND_OVERSIZE)) |-> res_r.last_in_msg)
    else $error("error result not marked end of message");

  a_data_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && res_r.kind != rcd_pkg::KIND_DATA) |-> (res_r.data_byte == 8'd0))
    else $error("data byte set on a non-data result");

endmodule

### rtl/rcd_cfg.sv
// Configuration register file for the command deframer.
// Depends on rcd_pkg (cfg_t, register indexes, reset values).
module rcd_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [31:0]       cfg_wdata,
  output rcd_pkg::cfg_t     cfg
);

  rcd_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_index)
        rcd_pkg::CFG_MAX_ARG_COUNT:   cfg_nxt.max_arg_count   = cfg_wdata[7:0];
        rcd_pkg::CFG_MAX_BULK_LENGTH: cfg_nxt.max_bulk_length = cfg_wdata;
        default:                      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_arg_count   <= rcd_pkg::MAX_ARG_COUNT_RST;
      cfg_r.max_bulk_length <= rcd_pkg::MAX_BULK_LENGTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/rcd_parser.sv
// Parse state machine: per-byte next state and result decode.
// Depends on rcd_pkg (phase_t, res_t, cfg_t, character codes).
module rcd_parser #(
  parameter int LENGTH_BITS = rcd_pkg::LENGTH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          step,
  input  logic [7:0]    byte_in,
  input  rcd_pkg::cfg_t cfg,
  output logic          res_valid,
  output rcd_pkg::res_t res
);

  localparam int NW = LENGTH_BITS + 1;          // number register width
  localparam int MW = NW + 4;                   // room for value*10+digit
  localparam int CW = (NW > 32) ? NW : 32;      // compare width

  rcd_pkg::phase_t        phase_r, phase_nxt;
  logic [NW-1:0]          num_r, num_nxt;
  logic                   neg_r, neg_nxt;
  logic [7:0]             args_r, args_nxt;
  logic [7:0]             cur_r, cur_nxt;
  logic [LENGTH_BITS-1:0] pl_r, pl_nxt;
  logic [1:0]             skip_r, skip_nxt;

  logic                   is_digit, is_sign, is_ws;
  logic [3:0]             digit;
  logic [MW-1:0]          mul;
  logic [NW-1:0]          num_sat;
  logic                   cnt_end, len_end;
  logic                   cnt_nonpos, cnt_over;
  logic                   len_null, len_over, len_empty;
  logic                   close_last;
  logic [LENGTH_BITS-1:0] pl_dec;
  logic [1:0]             skip_dec;

  assign is_digit = (byte_in >= rcd_pkg::CH_ZERO) && (byte_in <= rcd_pkg::CH_NINE);
  assign is_sign  = (byte_in == rcd_pkg::CH_PLUS) || (byte_in == rcd_pkg::CH_MINUS);
  assign is_ws    = byte_in inside {rcd_pkg::CH_SPACE, [rcd_pkg::CH_TAB:rcd_pkg::CH_CR]};
  assign digit    = byte_in[3:0];

  // value*10 + digit as two shifts and an add, saturating at all ones
  assign mul     = (MW'(num_r) << 3) + (MW'(num_r) << 1) + MW'(digit);
  assign num_sat = (|mul[MW-1:NW]) ? {NW{1'b1}} : mul[NW-1:0];

  assign cnt_end = ((phase_r == rcd_pkg::PH_CNT_START) && !is_sign && !is_digit) ||
                   ((phase_r == rcd_pkg::PH_CNT_DIGITS) && !is_digit);
  assign len_end = ((phase_r == rcd_pkg::PH_LEN_START) && !is_sign && !is_digit) ||
                   ((phase_r == rcd_pkg::PH_LEN_DIGITS) && !is_digit);

  assign cnt_nonpos = neg_r || (num_r == '0);
  assign cnt_over   = CW'(num_r) > CW'(cfg.max_arg_count);
  assign len_null   = neg_r && (num_r != '0);
  // top bit set means above the LENGTH_BITS cap
  assign len_over   = (CW'(num_r) > CW'(cfg.max_bulk_length)) || num_r[NW-1];
  assign len_empty  = (num_r == '0);

  assign close_last = ({1'b0, cur_r} + 9'd1) >= {1'b0, args_r};
  assign pl_dec     = pl_r - LENGTH_BITS'(1);
  assign skip_dec   = (skip_r == 2'd0) ? 2'd0 : skip_r - 2'd1;

  // Next state
  always_comb begin
    phase_nxt = phase_r;
    num_nxt   = num_r;
    neg_nxt   = neg_r;
    args_nxt  = args_r;
    cur_nxt   = cur_r;
    pl_nxt    = pl_r;
    skip_nxt  = skip_r;
    case (phase_r)
      rcd_pkg::PH_IDLE: begin
        if (byte_in == rcd_pkg::CH_STAR) begin
          phase_nxt = rcd_pkg::PH_CNT_START;
          num_nxt   = '0;
          neg_nxt   = 1'b0;
        end
      end
      rcd_pkg::PH_CNT_START, rcd_pkg::PH_CNT_DIGITS: begin
        if (cnt_end) begin
          args_nxt  = (cnt_nonpos || cnt_over) ? 8'd0 : num_r[7:0];
          cur_nxt   = 8'd0;
          phase_nxt = (cnt_nonpos || cnt_over) ? rcd_pkg::PH_SKIP_IDLE
                                               : rcd_pkg::PH_SKIP_ARGHDR;
          skip_nxt  = 2'd1;
        end else if (is_sign) begin
          neg_nxt   = (byte_in == rcd_pkg::CH_MINUS);
          phase_nxt = rcd_pkg::PH_CNT_DIGITS;
        end else begin
          num_nxt   = num_sat;
          phase_nxt = rcd_pkg::PH_CNT_DIGITS;
        end
      end
      rcd_pkg::PH_LEN_START, rcd_pkg::PH_LEN_DIGITS: begin
        if (len_end) begin
          if (len_null) begin
            cur_nxt   = cur_r + 8'd1;
            phase_nxt = close_last ? rcd_pkg::PH_SKIP_IDLE : rcd_pkg::PH_SKIP_ARGHDR;
            skip_nxt  = 2'd1;
          end else if (len_over) begin
            phase_nxt = rcd_pkg::PH_SKIP_IDLE;
            skip_nxt  = 2'd1;
          end else if (len_empty) begin
            cur_nxt   = cur_r + 8'd1;
            phase_nxt = close_last ? rcd_pkg::PH_SKIP_IDLE : rcd_pkg::PH_SKIP_ARGHDR;
            skip_nxt  = 2'd3;
          end else begin
            pl_nxt    = num_r[LENGTH_BITS-1:0];
            phase_nxt = rcd_pkg::PH_SKIP_PAYLOAD;
            skip_nxt  = 2'd1;
          end
        end else if (is_sign) begin
          neg_nxt   = (byte_in == rcd_pkg::CH_MINUS);
          phase_nxt = rcd_pkg::PH_LEN_DIGITS;
        end else begin
          num_nxt   = num_sat;
          phase_nxt = rcd_pkg::PH_LEN_DIGITS;
        end
      end
      rcd_pkg::PH_ARG_HDR: begin
        if (byte_in == rcd_pkg::CH_DOLLAR) begin
          phase_nxt = rcd_pkg::PH_LEN_START;
          num_nxt   = '0;
          neg_nxt   = 1'b0;
        end else begin
          phase_nxt = rcd_pkg::PH_IDLE;
        end
      end
      rcd_pkg::PH_PAYLOAD: begin
        pl_nxt = pl_dec;
        if (pl_dec == '0) begin
          cur_nxt   = cur_r + 8'd1;
          phase_nxt = close_last ? rcd_pkg::PH_SKIP_IDLE : rcd_pkg::PH_SKIP_ARGHDR;
          skip_nxt  = 2'd2;
        end
      end
      rcd_pkg::PH_SKIP_IDLE, rcd_pkg::PH_SKIP_ARGHDR, rcd_pkg::PH_SKIP_PAYLOAD: begin
        skip_nxt = skip_dec;
        if (skip_dec == 2'd0) begin
          case (phase_r)
            rcd_pkg::PH_SKIP_IDLE:   phase_nxt = rcd_pkg::PH_IDLE;
            rcd_pkg::PH_SKIP_ARGHDR: phase_nxt = rcd_pkg::PH_ARG_HDR;
            default:                 phase_nxt = rcd_pkg::PH_PAYLOAD;
          endcase
        end
      end
      default: phase_nxt = rcd_pkg::PH_IDLE;
    endcase
  end

  // Result decode
  always_comb begin
    res_valid       = 1'b0;
    res.kind        = rcd_pkg::KIND_HEADER;
    res.arg_index   = 8'd0;
    res.arg_count   = 8'd0;
    res.data_byte   = 8'd0;
    res.last_in_arg = 1'b0;
    res.last_in_msg = 1'b0;
    case (phase_r)
      rcd_pkg::PH_IDLE: begin
        if ((byte_in != rcd_pkg::CH_STAR) && !is_ws) begin
          res_valid       = 1'b1;
          res.kind        = rcd_pkg::KIND_NOT_ARRAY;
          res.last_in_msg = 1'b1;
        end
      end
      rcd_pkg::PH_CNT_START, rcd_pkg::PH_CNT_DIGITS: begin
        if (cnt_end) begin
          res_valid = 1'b1;
          if (cnt_nonpos) begin
            res.last_in_msg = 1'b1;
          end else if (cnt_over) begin
            res.kind        = rcd_pkg::KIND_OVERSIZE;
            res.last_in_msg = 1'b1;
          end else begin
            res.arg_count = num_r[7:0];
          end
        end
      end
      rcd_pkg::PH_LEN_START, rcd_pkg::PH_LEN_DIGITS: begin
        res.arg_index = cur_r;
        res.arg_count = args_r;
        if (len_end) begin
          if (len_null) begin
            res_valid       = 1'b1;
            res.kind        = rcd_pkg::KIND_NULL_ARG;
            res.last_in_arg = 1'b1;
            res.last_in_msg = close_last;
          end else if (len_over) begin
            res_valid       = 1'b1;
            res.kind        = rcd_pkg::KIND_OVERSIZE;
            res.last_in_msg = 1'b1;
          end else if (len_empty) begin
            res_valid       = 1'b1;
            res.kind        = rcd_pkg::KIND_EMPTY_ARG;
            res.last_in_arg = 1'b1;
            res.last_in_msg = close_last;
          end
        end
      end
      rcd_pkg::PH_ARG_HDR: begin
        res.arg_index = cur_r;
        res.arg_count = args_r;
        if (byte_in != rcd_pkg::CH_DOLLAR) begin
          res_valid       = 1'b1;
          res.kind        = rcd_pkg::KIND_BAD_HDR;
          res.last_in_msg = 1'b1;
        end
      end
      rcd_pkg::PH_PAYLOAD: begin
        res_valid       = 1'b1;
        res.kind        = rcd_pkg::KIND_DATA;
        res.arg_index   = cur_r;
        res.arg_count   = args_r;
        res.data_byte   = byte_in;
        res.last_in_arg = (pl_dec == '0);
        res.last_in_msg = (pl_dec == '0) && close_last;
      end
      default: res_valid = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rcd_pkg::PH_IDLE;
      num_r   <= '0;
      neg_r   <= 1'b0;
      args_r  <= 8'd0;
      cur_r   <= 8'd0;
      pl_r    <= '0;
      skip_r  <= 2'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      num_r   <= num_nxt;
      neg_r   <= neg_nxt;
      args_r  <= args_nxt;
      cur_r   <= cur_nxt;
      pl_r    <= pl_nxt;
      skip_r  <= skip_nxt;
    end
  end

  a_skip_only_in_skip: assert property (@(posedge clk) disable iff (!rst_n)
    (skip_r != 2'd0) |-> (phase_r == rcd_pkg::PH_SKIP_IDLE ||
                          phase_r == rcd_pkg::PH_SKIP_ARGHDR ||
                          phase_r == rcd_pkg::PH_SKIP_PAYLOAD))
    else $error("skip count set outside a skip phase");

  a_payload_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == rcd_pkg::PH_PAYLOAD) |-> (pl_r != '0))
    else $error("payload phase with no bytes left");

  a_msg_end_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (step && res_valid && res.last_in_msg) |=>
      (phase_r == rcd_pkg::PH_IDLE || phase_r == rcd_pkg::PH_SKIP_IDLE))
    else $error("message ended but parser not heading to idle");

endmodule

### sim/tb_top.sv
// Testbench for resp_command_deframer_unit: byte stream in, parsed results out.
// Holds its own predictor and result scoreboard.
// Depends on rtl/rcd_pkg.sv and rtl/resp_command_deframer_unit.sv.
module tb_top;
  import rcd_pkg::*;

  // Cycles with no transaction on either channel before the run is abandoned
  localparam int STALL_LIMIT = 4000;
  // Saturation points of the number parser and of an accepted length
  localparam logic [63:0] NUM_SAT = 64'h1_FFFF_FFFF;
  localparam logic [63:0] LEN_SAT = 64'h0_FFFF_FFFF;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_byte = 8'h00;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_kind;
  logic [7:0]  out_arg_index;
  logic [7:0]  out_arg_count;
  logic [7:0]  out_data_byte;
  logic        out_last_in_arg;
  logic        out_last_in_msg;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [31:0] cfg_wdata = 32'h0;

  resp_command_deframer_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
    .out_valid(out_valid), .out_ready(out_ready), .out_kind(out_kind),
    .out_arg_index(out_arg_index), .out_arg_count(out_arg_count),
    .out_data_byte(out_data_byte), .out_last_in_arg(out_last_in_arg),
    .out_last_in_msg(out_last_in_msg),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Parser mirror. Updated at the edge where a byte transaction completes, so
  // its state always reflects every byte the block has accepted so far.
  // ---------------------------------------------------------------------------
  cfg_t        limits = '{max_arg_count: MAX_ARG_COUNT_RST,
                          max_bulk_length: MAX_BULK_LENGTH_RST};
  phase_t      phase = PH_IDLE;
  logic [63:0] num_val = '0;     // magnitude, saturates at NUM_SAT
  bit          num_neg = 1'b0;
  logic [7:0]  msg_args = '0;    // argument count of the open message
  logic [7:0]  cur_arg = '0;
  logic [31:0] bytes_left = '0;  // payload bytes still to come
  logic [1:0]  skip_cnt = '0;    // unchecked bytes still to drop

  res_t pending_results[$];      // results owed by the block, oldest first
  res_t want;
  int   mismatches = 0;
  int   bytes_sent = 0;
  bit   calm = 1'b0;             // when set, neither side inserts idle cycles
  logic [7:0] frame_bytes[$];    // stream under construction
  int   stall_cycles = 0;

  function automatic res_t make_res(kind_t k, logic [7:0] idx, logic [7:0] cnt,
                                    logic [7:0] d, bit la, bit lm);
    res_t r;
    r.kind = k;
    r.arg_index = idx;
    r.arg_count = cnt;
    r.data_byte = d;
    r.last_in_arg = la;
    r.last_in_msg = lm;
    return r;
  endfunction

  function automatic void enter_skip(phase_t ph, logic [1:0] n);
    phase = ph;
    skip_cnt = n;
  endfunction

  function automatic void begin_number(phase_t ph);
    phase = ph;
    num_val = '0;
    num_neg = 1'b0;
  endfunction

  function automatic void add_digit(logic [7:0] b);
    logic [63:0] nv;
    nv = num_val * 64'd10 + {56'd0, b - CH_ZERO};
    num_val = (nv > NUM_SAT) ? NUM_SAT : nv;
  endfunction

  // Closes the current argument; returns 1 when it was the message's last.
  function automatic bit finish_arg(logic [1:0] n);
    bit is_last;
    is_last = ({1'b0, cur_arg} + 9'd1) >= {1'b0, msg_args};
    cur_arg = cur_arg + 8'd1;
    if (is_last) begin
      enter_skip(PH_SKIP_IDLE, n);
    end else begin
      enter_skip(PH_SKIP_ARGHDR, n);
    end
    return is_last;
  endfunction

  function automatic res_t count_done();
    if (num_neg || num_val == 0) begin
      msg_args = '0;
      cur_arg = '0;
      enter_skip(PH_SKIP_IDLE, 2'd1);
      return make_res(KIND_HEADER, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    end
    if (num_val > {56'd0, limits.max_arg_count}) begin
      msg_args = '0;
      cur_arg = '0;
      enter_skip(PH_SKIP_IDLE, 2'd1);
      return make_res(KIND_OVERSIZE, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
    end
    msg_args = num_val[7:0];
    cur_arg = '0;
    enter_skip(PH_SKIP_ARGHDR, 2'd1);
    return make_res(KIND_HEADER, 8'd0, msg_args, 8'd0, 1'b0, 1'b0);
  endfunction

  function automatic bit length_done(output res_t r);
    logic [7:0] idx;
    bit is_last;
    idx = cur_arg;
    r = '0;
    // any nonzero negative length is a null argument; "-0" falls through
    if (num_neg && num_val != 0) begin
      is_last = finish_arg(2'd1);
      r = make_res(KIND_NULL_ARG, idx, msg_args, 8'd0, 1'b1, is_last);
      return 1'b1;
    end
    if (num_val > {32'd0, limits.max_bulk_length} || num_val > LEN_SAT) begin
      enter_skip(PH_SKIP_IDLE, 2'd1);
      r = make_res(KIND_OVERSIZE, idx, msg_args, 8'd0, 1'b0, 1'b1);
      return 1'b1;
    end
    if (num_val == 0) begin
      is_last = finish_arg(2'd3);
      r = make_res(KIND_EMPTY_ARG, idx, msg_args, 8'd0, 1'b1, is_last);
      return 1'b1;
    end
    bytes_left = num_val[31:0];
    enter_skip(PH_SKIP_PAYLOAD, 2'd1);
    return 1'b0;
  endfunction

  // Advances the mirror by one byte; returns 1 with the result when one is due.
  function automatic bit deframe_byte(logic [7:0] b, output res_t r);
    bit is_digit;
    bit is_last;
    logic [7:0] idx;
    phase_t nxt;
    is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    r = '0;
    case (phase)
      PH_IDLE: begin
        if (b == CH_STAR) begin
          begin_number(PH_CNT_START);
          return 1'b0;
        end
        // whitespace between messages is dropped silently
        if (b == CH_SPACE || (b >= CH_TAB && b <= CH_CR)) return 1'b0;
        r = make_res(KIND_NOT_ARRAY, 8'd0, 8'd0, 8'd0, 1'b0, 1'b1);
        return 1'b1;
      end
      PH_CNT_START, PH_LEN_START: begin
        if (phase == PH_CNT_START) begin
          nxt = PH_CNT_DIGITS;
        end else begin
          nxt = PH_LEN_DIGITS;
        end
        if (b == CH_PLUS || b == CH_MINUS) begin
          num_neg = (b == CH_MINUS);
          phase = nxt;
          return 1'b0;
        end
        if (is_digit) begin
          add_digit(b);
          phase = nxt;
          return 1'b0;
        end
        if (phase == PH_CNT_START) begin
          r = count_done();
          return 1'b1;
        end
        return length_done(r);
      end
      PH_CNT_DIGITS: begin
        if (is_digit) begin
          add_digit(b);
          return 1'b0;
        end
        r = count_done();
        return 1'b1;
      end
      PH_LEN_DIGITS: begin
        if (is_digit) begin
          add_digit(b);
          return 1'b0;
        end
        return length_done(r);
      end
      PH_ARG_HDR: begin
        if (b == CH_DOLLAR) begin
          begin_number(PH_LEN_START);
          return 1'b0;
        end
        phase = PH_IDLE;
        r = make_res(KIND_BAD_HDR, cur_arg, msg_args, 8'd0, 1'b0, 1'b1);
        return 1'b1;
      end
      PH_PAYLOAD: begin
        idx = cur_arg;
        bytes_left = bytes_left - 32'd1;
        if (bytes_left == 0) begin
          is_last = finish_arg(2'd2);
          r = make_res(KIND_DATA, idx, msg_args, b, 1'b1, is_last);
        end else begin
          r = make_res(KIND_DATA, idx, msg_args, b, 1'b0, 1'b0);
        end
        return 1'b1;
      end
      PH_SKIP_IDLE, PH_SKIP_ARGHDR, PH_SKIP_PAYLOAD: begin
        if (skip_cnt != 0) skip_cnt = skip_cnt - 2'd1;
        if (skip_cnt == 0) begin
          case (phase)
            PH_SKIP_IDLE:   phase = PH_IDLE;
            PH_SKIP_ARGHDR: phase = PH_ARG_HDR;
            default:        phase = PH_PAYLOAD;
          endcase
        end
        return 1'b0;
      end
      default: begin
        phase = PH_IDLE;
        return 1'b0;
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stream construction
  // ---------------------------------------------------------------------------
  function automatic void put_byte(logic [7:0] v);
    frame_bytes.push_back(v);
  endfunction

  function automatic void put_text(string s);
    for (int i = 0; i < s.len(); i++) frame_bytes.push_back(s[i]);
  endfunction

  // Optional sign character (8'h00 for none) followed by decimal digits.
  function automatic void put_number(logic [7:0] sign, longint unsigned mag);
    if (sign != 8'h00) put_byte(sign);
    put_text($sformatf("%0d", mag));
  endfunction

  // Number terminator plus the unchecked byte after it; mostly CR LF.
  function automatic void put_end();
    logic [7:0] t;
    if ($urandom_range(0, 3) != 0) begin
      put_byte(8'h0D);
      put_byte(8'h0A);
      return;
    end
    do t = 8'($urandom_range(0, 255)); while (t >= CH_ZERO && t <= CH_NINE);
    put_byte(t);
    put_byte(8'($urandom_range(0, 255)));
  endfunction

  // One message with random content. Most are well formed; a few carry a
  // non-positive or oversize count, a bad argument header or an oversize length.
  function automatic void build_message(int unsigned max_args, int unsigned max_payload);
    int unsigned n_args;
    int unsigned mode;
    int unsigned len;
    repeat ($urandom_range(0, 2)) put_byte($urandom_range(0, 1) ? CH_SPACE : 8'h0A);
    put_byte(CH_STAR);
    mode = $urandom_range(0, 19);
    if (mode == 0) begin
      put_number(CH_MINUS, $urandom_range(0, 3));
      put_end();
      return;
    end
    if (mode == 1) begin
      put_number(8'h00, limits.max_arg_count + 1 + $urandom_range(0, 300));
      put_end();
      return;
    end
    if (mode == 2) begin
      put_end();    // no digits at all: count of zero
      return;
    end
    n_args = $urandom_range(1, max_args);
    put_number(mode == 3 ? CH_PLUS : 8'h00, n_args);
    put_end();
    for (int unsigned i = 0; i < n_args; i++) begin
      mode = $urandom_range(0, 39);
      if (mode == 0) begin
        put_byte($urandom_range(0, 1) ? 8'h23 : CH_STAR);
        return;
      end
      put_byte(CH_DOLLAR);
      if (mode < 4) begin
        put_number(CH_MINUS, $urandom_range(1, 999));
        put_end();
      end else if (mode < 7) begin
        put_number(mode == 4 ? CH_MINUS : 8'h00, 0);
        put_end();
        put_end();
      end else if (mode == 7) begin
        put_number(8'h00, longint'(limits.max_bulk_length) + 1 + $urandom_range(0, 9));
        put_end();
        return;
      end else if (mode == 8) begin
        put_text("98765432109876543210");
        put_end();
        return;
      end else begin
        len = $urandom_range(1, max_payload);
        put_number(mode == 9 ? CH_PLUS : 8'h00, len);
        put_end();
        repeat (len) put_byte(8'($urandom_range(0, 255)));
        put_end();
      end
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------
  task automatic send_byte(logic [7:0] b);
    res_t r;
    @(negedge clk);
    while (!calm && $urandom_range(0, 99) < 24) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte <= b;
    do @(posedge clk); while (!in_ready);
    bytes_sent++;
    if (deframe_byte(b, r)) pending_results.push_back(r);
  endtask

  task automatic send_frame();
    while (frame_bytes.size() != 0) send_byte(frame_bytes.pop_front());
  endtask

  // Feeds line feeds until the parser is back between messages.
  task automatic settle_idle();
    for (int i = 0; i < 4096 && phase != PH_IDLE; i++) send_byte(8'h0A);
  endtask

  // Stops the stream and lets everything in flight come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    // bytes that produce no result may still sit in the input register
    repeat (4) @(negedge clk);
  endtask

  task automatic write_cfg(logic idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_MAX_ARG_COUNT) begin
      limits.max_arg_count = val[7:0];
    end else begin
      limits.max_bulk_length = val;
    end
  endtask

  always @(negedge clk) out_ready <= calm || ($urandom_range(0, 99) >= 24);

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------
  task automatic report_mismatch(string what);
    if (mismatches < 40) $display("mismatch @%0t: %s", $time, what);
    mismatches++;
  endtask

  task automatic compare_field(string name, logic [7:0] got, logic [7:0] exp);
    if (got !== exp) report_mismatch($sformatf("%s got %0h want %0h", name, got, exp));
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result kind %0d arrived with none owed", out_kind));
      end else begin
        want = pending_results.pop_front();
        compare_field("kind", {5'd0, out_kind}, {5'd0, want.kind});
        compare_field("arg_index", out_arg_index, want.arg_index);
        compare_field("arg_count", out_arg_count, want.arg_count);
        compare_field("data_byte", out_data_byte, want.data_byte);
        compare_field("last_in_arg", {7'd0, out_last_in_arg}, {7'd0, want.last_in_arg});
        compare_field("last_in_msg", {7'd0, out_last_in_msg}, {7'd0, want.last_in_msg});
      end
    end
  end

  // Watchdog: a hung channel or a result that never shows up ends here.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles == STALL_LIMIT) begin
      $display("[resp_command_deframer_unit] ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Whitespace 9..13 and space is dropped; neighbors 8 and 14 are not.
  task automatic test_leading_bytes();
    settle_idle();
    put_text(" \t\n\013\014\015x");
    put_byte(8'h00);
    put_byte(8'hFF);
    put_byte(8'h08);
    put_byte(8'h0E);
    put_byte(CH_DOLLAR);
    send_frame();
  endtask

  // Zero, negative, signed-zero and missing counts all close the message.
  task automatic test_counts();
    settle_idle();
    put_text("*0\015\012*-3\015\012*\015\012*+0\015\012*-0\015\012");
    send_frame();
  endtask

  // Data, empty, null, "-0" and "+" lengths inside one message.
  task automatic test_arguments();
    settle_idle();
    put_text("*5\015\012$3\015\012ab");
    put_byte(8'hFF);
    put_text("\015\012$0\015\012\015\012$-1\015\012$-0\015\012\015\012$+2\015\012");
    put_byte(8'h00);
    put_text("z\015\012");
    send_frame();
  endtask

  task automatic test_bad_header();
    settle_idle();
    put_text("*2\015\012$1\015\012q\015\012#");
    send_frame();
  endtask

  // Count and length limits at reset values, plus a saturating number.
  task automatic test_oversize();
    settle_idle();
    put_text("*256\015\012*99999999999999999999\015\012");
    put_text("*1\015\012$536870913\015\012");
    put_text("*1\015\012$99999999999999999999\015\012");
    send_frame();
  endtask

  // Top register values: a count of 255 accepted and the length ceiling.
  task automatic test_wide_limits();
    wait_drained();
    write_cfg(CFG_MAX_ARG_COUNT, 32'd255);
    write_cfg(CFG_MAX_BULK_LENGTH, 32'hFFFF_FFFF);
    settle_idle();
    put_text("*1\015\012$4294967296\015\012");
    put_text("*1\015\012$-99999999999999999999\015\012");
    // 255-argument message cut short by a bad header on the third argument
    put_text("*255\015\012$-1\015\012$2\015\012");
    put_byte(8'hFF);
    put_byte(8'h00);
    put_text("\015\012#");
    send_frame();
  endtask

  // Bottom register values: zero length limit, then a zero count limit.
  task automatic test_tight_limits();
    wait_drained();
    write_cfg(CFG_MAX_ARG_COUNT, 32'd1);
    write_cfg(CFG_MAX_BULK_LENGTH, 32'd0);
    settle_idle();
    put_text("*1\015\012$1\015\012*1\015\012$0\015\012\015\012*2\015\012");
    send_frame();
    wait_drained();
    write_cfg(CFG_MAX_ARG_COUNT, 32'd0);
    write_cfg(CFG_MAX_BULK_LENGTH, 32'd5);
    settle_idle();
    put_text("*1\015\012*0\015\012");
    send_frame();
  endtask

  // Mostly whole messages; the rest is line noise and cut-off messages.
  task automatic run_random(int n_bytes, int unsigned max_args, int unsigned max_payload);
    int stop_at;
    int unsigned pick;
    stop_at = bytes_sent + n_bytes;
    while (bytes_sent < stop_at) begin
      pick = $urandom_range(0, 9);
      if (pick < 2) begin
        repeat ($urandom_range(1, 6)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        build_message(max_args, max_payload);
        if (pick == 2) begin
          repeat ($urandom_range(1, 8)) begin
            if (frame_bytes.size() > 1) void'(frame_bytes.pop_back());
          end
        end
      end
      send_frame();
    end
  endtask

  task automatic test_random_traffic();
    wait_drained();
    write_cfg(CFG_MAX_ARG_COUNT, 32'd3);
    write_cfg(CFG_MAX_BULK_LENGTH, 32'd12);
    run_random(30, 4, 14);
    wait_drained();
    write_cfg(CFG_MAX_ARG_COUNT, {24'd0, MAX_ARG_COUNT_RST});
    write_cfg(CFG_MAX_BULK_LENGTH, MAX_BULK_LENGTH_RST);
    calm = 1'b1;    // back-to-back stretch on both channels
    run_random(80, 5, 12);
    calm = 1'b0;
    wait_drained();
    write_cfg(CFG_MAX_ARG_COUNT, 32'd8);
    write_cfg(CFG_MAX_BULK_LENGTH, 32'd40);
    run_random(30, 4, 12);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_leading_bytes();
    test_counts();
    test_arguments();
    test_bad_header();
    test_oversize();
    test_wide_limits();
    test_tight_limits();
    test_random_traffic();

    // Anything still owed that never arrives trips the watchdog instead.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("[resp_command_deframer_unit] OK");
    end else begin
      $display("[resp_command_deframer_unit] ERROR");
    end
    $finish;
  end

endmodule
